[rtl/slid_pkg.sv]
// Shared types and constants for the sorted list insert/delete unit.
// Used by every module under rtl/; it depends on nothing else.
`timescale 1ns / 1ps

package slid_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int VALUE_W        = 32;
    localparam int OP_W           = 2;
    localparam int COUNT_OUT_W    = 7;
    localparam int S_TDATA_W      = 32;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CMP,
        BK_APPLY
    } back_state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic                     found;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     is_empty;
        logic                     is_full;
    } result_t;

endpackage

[rtl/slid_front.sv]
// Front end: takes items from the input stream, decodes the operation and
// holds the command in a register for the queue. Depends on slid_pkg.
`timescale 1ns / 1ps

module slid_front import slid_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;

    // The register frees up in the same cycle the queue takes its item.
    assign s_tready = !cmd_valid_reg || cmd_ready;

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (s_tready) begin
            cmd_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg.op    <= op_t'(s_tuser[OP_W-1:0]);
            cmd_reg.value <= s_tdata[VALUE_W-1:0];
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

[rtl/slid_queue.sv]
// Short command queue between the front end and the list engine.
// Depends on slid_pkg for the command type and the queue depth.
`timescale 1ns / 1ps

module slid_queue import slid_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             push;
    logic             pop;

    assign in_ready  = fill_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/slid_back.sv]
// List engine: a row of sorted cells, a compare step and an apply step that
// shifts cells in parallel, plus the result register. Depends on slid_pkg.
`timescale 1ns / 1ps

module slid_back import slid_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    back_state_t               state_reg;
    back_state_t               state_next;
    cmd_t                      cmd_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [LIST_DEPTH-1:0]     gtv_reg;
    logic [LIST_DEPTH-1:0]     gtv_next;
    logic [LIST_DEPTH-1:0]     gev_reg;
    logic [LIST_DEPTH-1:0]     gev_next;
    logic signed [VALUE_W-1:0] cells [LIST_DEPTH];
    logic signed [VALUE_W-1:0] ins_val [LIST_DEPTH];
    logic signed [VALUE_W-1:0] del_val [LIST_DEPTH];
    logic                      res_valid_reg;
    result_t                   res_reg;
    result_t                   res_next;
    logic                      commit;
    logic                      pop;
    logic                      found;
    logic                      do_ins;
    logic                      do_del;
    status_t                   status;

    assign commit    = (state_reg == BK_APPLY) && (!res_valid_reg || res_ready);
    assign cmd_ready = (state_reg == BK_IDLE) || commit;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    state_next = BK_CMP;
                end
            end
            BK_CMP: begin
                state_next = BK_APPLY;
            end
            BK_APPLY: begin
                if (commit) begin
                    state_next = cmd_valid ? BK_CMP : BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Cells at or above the count rank above the value but never match it,
    // so an insert lands in the first of them if no cell is larger.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (CW'(i) < count_reg) begin
                gtv_next[i] = cells[i] > cmd_reg.value;
                gev_next[i] = cells[i] >= cmd_reg.value;
            end else begin
                gtv_next[i] = 1'b1;
                gev_next[i] = 1'b0;
            end
        end
    end

    // Cells are sorted, so the cells at or above the first match are exactly
    // those not below the value; a delete pulls all of them down one place.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (!gtv_reg[i]) begin
                ins_val[i] = cells[i];
            end else if (i > 0 && gtv_reg[(i > 0) ? i - 1 : 0]) begin
                ins_val[i] = cells[(i > 0) ? i - 1 : 0];
            end else begin
                ins_val[i] = cmd_reg.value;
            end
            if (gev_reg[i] && i < LIST_DEPTH - 1) begin
                del_val[i] = cells[(i < LIST_DEPTH - 1) ? i + 1 : i];
            end else begin
                del_val[i] = cells[i];
            end
        end
    end

    always_comb begin
        found      = |(gev_reg & ~gtv_reg);
        status     = ST_OK;
        count_next = count_reg;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        unique case (cmd_reg.op)
            OP_INSERT: begin
                if (count_reg == CW'(LIST_DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DELETE: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else if (!found) begin
                    status = ST_NOTFOUND;
                end else begin
                    do_del     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_LOOKUP: begin
                status = found ? ST_OK : ST_NOTFOUND;
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
        res_next.status      = status;
        res_next.found       = found;
        res_next.entry_count = COUNT_OUT_W'(count_next);
        res_next.is_empty    = count_next == '0;
        res_next.is_full     = count_next == CW'(LIST_DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= cmd;
        end
        if (state_reg == BK_CMP) begin
            gtv_reg <= gtv_next;
            gev_reg <= gev_next;
        end
        if (commit) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (commit && do_ins) begin
                cells[i] <= ins_val[i];
            end else if (commit && do_del) begin
                cells[i] <= del_val[i];
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[rtl/sorted_list_insert_delete_unit.sv]
// Top level of the sorted list insert/delete unit: front end, command queue
// and list engine. Depends on slid_pkg, slid_front, slid_queue, slid_back.
//
//  channel  | direction | tdata (low bit up)                       | tuser
//  ---------+-----------+------------------------------------------+---------
//  s_axis   | in        | value[31:0]                              | op[1:0]
//  m_axis   | out       | status[1:0] found[2] entry_count[9:3]    | -
//           |           | is_empty[10] is_full[11] zeros[15:12]    |
//
// An item passes through the front register and the queue; the list engine
// then handles it in a compare step and an apply step (parallel shift and
// result) and takes the next item only as it commits the last one's result,
// so its compare/apply sequence sets the sustained rate.
// Reset (aresetn low, synchronous) empties the list and all control state.
// A stalled result holds the engine in its apply step; the queue keeps
// taking items until it is full.
`timescale 1ns / 1ps

module sorted_list_insert_delete_unit import slid_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // value[31:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // op[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // status, found, entry_count,
                                                 // is_empty, is_full, zeros
);

    logic    fq_valid;
    logic    fq_ready;
    cmd_t    fq_cmd;
    logic    qb_valid;
    logic    qb_ready;
    cmd_t    qb_cmd;
    result_t res;

    slid_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    slid_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    slid_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {4'b0000, res.is_full, res.is_empty, res.entry_count,
                           res.found, res.status};

    // A full list is never empty, and refusing an insert means it was full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res.is_full |-> !res.is_empty)
        else $error("result flags both full and empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (res.status == ST_FULL) |-> res.is_full)
        else $error("insert refused while list not full");

    // A refused delete means nothing was stored.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (res.status == ST_EMPTY) |-> res.is_empty && !res.found)
        else $error("delete refused while list not empty");

    // A not-found status means the value was absent before the operation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (res.status == ST_NOTFOUND) |-> !res.found)
        else $error("not-found status with value present");

endmodule

[verif/tb_sorted_list_insert_delete_unit.sv]
// Self-checking testbench for sorted_list_insert_delete_unit: a scoreboard class keeps its
// own sorted list, predicts every result and checks the result stream in order.
// Depends on slid_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

import slid_pkg::*;

class list_scoreboard;
    logic signed [VALUE_W-1:0] sorted_vals[$];
    result_t                   awaited_q[$];
    int                        errors;

    function new();
        errors = 0;
    endfunction

    function int pending_count();
        return awaited_q.size();
    endfunction

    // Apply one accepted item to the shadow list and queue the result it must produce.
    function void note_item(op_t op, logic signed [VALUE_W-1:0] val);
        int      n;
        int      hit;
        int      pos;
        result_t res;
        n   = sorted_vals.size();
        hit = n;
        pos = n;
        for (int i = 0; i < n; i++) begin
            if (hit == n && sorted_vals[i] == val) hit = i;
            if (pos == n && sorted_vals[i] > val) pos = i;
        end
        res.status = ST_OK;
        res.found  = (hit < n);
        case (op)
            OP_INSERT: begin
                if (n >= LIST_DEPTH_DEF) res.status = ST_FULL;
                else sorted_vals.insert(pos, val);
            end
            OP_DELETE: begin
                if (n == 0) res.status = ST_EMPTY;
                else if (hit == n) res.status = ST_NOTFOUND;
                else sorted_vals.delete(hit);
            end
            OP_LOOKUP: begin
                res.status = (hit < n) ? ST_OK : ST_NOTFOUND;
            end
            default: begin
                sorted_vals.delete();
            end
        endcase
        n               = sorted_vals.size();
        res.entry_count = n[COUNT_OUT_W-1:0];
        res.is_empty    = (n == 0);
        res.is_full     = (n == LIST_DEPTH_DEF);
        awaited_q.push_back(res);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
        end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata);
        result_t exp_res;
        if (awaited_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual tdata 0x%04h", $time,
                     tdata);
            return;
        end
        exp_res = awaited_q.pop_front();
        compare_field("status", exp_res.status, tdata[1:0]);
        compare_field("found", exp_res.found, tdata[2]);
        compare_field("entry_count", exp_res.entry_count, tdata[9:3]);
        compare_field("is_empty", exp_res.is_empty, tdata[10]);
        compare_field("is_full", exp_res.is_full, tdata[11]);
    endfunction
endclass

module tb_sorted_list_insert_delete_unit;

    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_ITEMS  = 200;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_PROBE
    } mix_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    list_scoreboard sb = new();
    bit             idle_on      = 1'b1;
    bit             hold_request = 1'b0;

    sorted_list_insert_delete_unit #(
        .LIST_DEPTH(LIST_DEPTH_DEF)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one item, with an optional idle burst first, and wait for it to be taken.
    task automatic send_item(input op_t op, input logic [VALUE_W-1:0] val);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(op, val);
    endtask

    function automatic op_t pick_op(mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:     return r < 85 ? OP_INSERT : (r < 93 ? OP_LOOKUP : OP_DELETE);
            MIX_DRAIN:    return r < 80 ? OP_DELETE : (r < 92 ? OP_LOOKUP : OP_INSERT);
            MIX_BALANCED: return r < 40 ? OP_INSERT : (r < 70 ? OP_DELETE :
                                 (r < 95 ? OP_LOOKUP : OP_CLEAR));
            default:      return r < 30 ? OP_INSERT : (r < 45 ? OP_DELETE :
                                 (r < 98 ? OP_LOOKUP : OP_CLEAR));
        endcase
    endfunction

    // Mostly values already stored or from a narrow band, so hits and duplicates are common.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = sb.sorted_vals.size();
        if (r < 45 && n > 0) return sb.sorted_vals[$urandom_range(0, n - 1)];
        if (r < 75) return $signed($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int   sent;
        int   seg_len;
        int   seg_idx;
        mix_t mix;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty-list corner cases, extremes, duplicates and clear reporting prior membership.
        send_item(OP_CLEAR, 32'd0);
        send_item(OP_DELETE, 32'd5);
        send_item(OP_LOOKUP, 32'd0);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'd0);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'd0);
        send_item(OP_LOOKUP, 32'd0);
        send_item(OP_LOOKUP, 32'd5);
        send_item(OP_DELETE, 32'd5);
        send_item(OP_DELETE, 32'd0);
        send_item(OP_LOOKUP, 32'd0);
        send_item(OP_DELETE, 32'h8000_0000);
        send_item(OP_DELETE, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'd3);
        send_item(OP_INSERT, 32'd3);
        send_item(OP_INSERT, 32'd3);
        send_item(OP_DELETE, 32'd3);
        send_item(OP_LOOKUP, 32'd3);
        send_item(OP_CLEAR, 32'd3);
        send_item(OP_CLEAR, 32'd3);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF);

        // The first segments fill the list past full and then drain it past empty.
        hold_request = 1'b1;
        sent    = 0;
        seg_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg_idx == 0) mix = MIX_FILL;
            else if (seg_idx == 1) mix = MIX_DRAIN;
            else mix = mix_t'($urandom_range(0, 3));
            seg_len = $urandom_range(80, 140);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                if (sent == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
                send_item(pick_op(mix), pick_value());
                sent++;
            end
            seg_idx++;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
